### src/sle_pkg.sv
// Shared types, field layout and microcode program of the list engine.
`default_nettype none

package sle_pkg;

  // Default depth of the list.
  localparam int CAPACITY_DEF = 16;

  // Identifier width; it matches the fixed key and assigned-id fields.
  localparam int ID_BITS = 16;

  // Field widths of the command and result beats.
  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int KEY_W  = 16;
  localparam int STAT_W = 8;
  localparam int CODE_W = 3;
  localparam int FPOS_W = 4;
  localparam int CNT_W  = 5;
  localparam int AID_W  = 16;

  // Bit offsets inside the command beat.
  localparam int S_POS_LSB = OP_W;
  localparam int S_KEY_LSB = S_POS_LSB + POS_W;
  localparam int S_ST_LSB  = S_KEY_LSB + KEY_W;
  localparam int S_USED_W  = S_ST_LSB + STAT_W;
  localparam int M_USED_W  = CODE_W + FPOS_W + CNT_W + AID_W;

  // Bus widths, rounded up to whole bytes.
  localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

  // Program counter width of the sequencer.
  localparam int PC_W = 4;

  typedef logic [PC_W-1:0] pc_t;

  // Commands.
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_END    = 3'd1,
    OP_INS_AT     = 3'd2,
    OP_REMOVE_AT  = 3'd3,
    OP_REMOVE_ID  = 3'd4,
    OP_SEARCH     = 3'd5,
    OP_SET_STATUS = 3'd6,
    OP_NOP        = 3'd7
  } op_e;

  // Result codes.
  typedef enum logic [CODE_W-1:0] {
    RC_OK       = 3'd0,
    RC_EMPTY    = 3'd1,
    RC_FULL     = 3'd2,
    RC_RANGE    = 3'd3,
    RC_NOTFOUND = 3'd4
  } rc_e;

  // Next-step selection of a control word.
  typedef enum logic [1:0] {
    NS_NEXT,      // step to pc + 1
    NS_BRANCH,    // jump to target if condition, else pc + 1
    NS_WAIT,      // jump to target if condition, else stay
    NS_DISPATCH   // jump to the entry point chosen by the command decode
  } ns_e;

  // Branch conditions.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_OUT_FREE,
    C_NO_SHIFT_UP,
    C_UP_MORE,
    C_NO_SHIFT_DN,
    C_DN_MORE,
    C_SCAN_MORE,
    C_HIT,
    C_OP_REMOVE,
    C_OP_SEARCH
  } cond_e;

  // Read address of the entry memory.
  typedef enum logic [2:0] {
    RA_ZERO,
    RA_OCC_M1,
    RA_IDX_M2,
    RA_AT_P1,
    RA_IDX_P1,
    RA_IDX_P2
  } ra_e;

  // Write to the entry memory.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,     // entry[idx] <= read data
    WR_NEW,       // entry[at]  <= fresh entry
    WR_STATUS     // entry[at]  <= key with new status
  } wr_e;

  // Update of the walk pointer.
  typedef enum logic [2:0] {
    IX_HOLD,
    IX_OCC,
    IX_AT,
    IX_ZERO,
    IX_INC,
    IX_DEC
  } ix_e;

  // Datapath register events.
  typedef enum logic [3:0] {
    EV_NONE,
    EV_ACCEPT,
    EV_DECODE,
    EV_INSERT,
    EV_REMOVE,
    EV_SCAN,
    EV_FOUND,
    EV_MISS,
    EV_EMIT
  } ev_e;

  // One control word of the program.
  typedef struct packed {
    ns_e   ns;
    cond_e cond;
    pc_t   target;
    ra_e   ra;
    wr_e   wr;
    ix_e   ix;
    ev_e   ev;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic accept;
    logic out_free;
    logic no_shift_up;
    logic up_more;
    logic no_shift_dn;
    logic dn_more;
    logic scan_more;
    logic hit;
    logic op_remove;
    logic op_search;
    pc_t  dispatch;
  } flags_t;

  // One list entry.
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [STAT_W-1:0]  status;
  } entry_t;

  // Program addresses.
  localparam pc_t P_IDLE      = 4'd0;
  localparam pc_t P_DECODE    = 4'd1;
  localparam pc_t P_INS       = 4'd2;
  localparam pc_t P_INS_SHIFT = 4'd3;
  localparam pc_t P_INS_PUT   = 4'd4;
  localparam pc_t P_REM       = 4'd5;
  localparam pc_t P_REM_SHIFT = 4'd6;
  localparam pc_t P_REM_END   = 4'd7;
  localparam pc_t P_SRCH      = 4'd8;
  localparam pc_t P_SRCH_SCAN = 4'd9;
  localparam pc_t P_SRCH_TEST = 4'd10;
  localparam pc_t P_MISS      = 4'd11;
  localparam pc_t P_FOUND     = 4'd12;
  localparam pc_t P_FOUND_SEL = 4'd13;
  localparam pc_t P_SET       = 4'd14;
  localparam pc_t P_EMIT      = 4'd15;

  // Microcode read-only table.
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    w = '{NS_NEXT, C_ALWAYS, P_IDLE, RA_ZERO, WR_NONE, IX_HOLD, EV_NONE};
    unique case (pc)
      // wait for a command beat
      P_IDLE:      w = '{NS_WAIT, C_ACCEPT, P_DECODE, RA_ZERO, WR_NONE, IX_HOLD, EV_ACCEPT};
      // check the command against the list, pick the routine
      P_DECODE:    w = '{NS_DISPATCH, C_ALWAYS, P_IDLE, RA_ZERO, WR_NONE, IX_HOLD, EV_DECODE};
      // insert: open a gap at the target position
      P_INS:       w = '{NS_BRANCH, C_NO_SHIFT_UP, P_INS_PUT, RA_OCC_M1, WR_NONE, IX_OCC,
                         EV_NONE};
      P_INS_SHIFT: w = '{NS_BRANCH, C_UP_MORE, P_INS_SHIFT, RA_IDX_M2, WR_SHIFT, IX_DEC,
                         EV_NONE};
      P_INS_PUT:   w = '{NS_BRANCH, C_ALWAYS, P_EMIT, RA_ZERO, WR_NEW, IX_HOLD, EV_INSERT};
      // remove: close the gap at the target position
      P_REM:       w = '{NS_BRANCH, C_NO_SHIFT_DN, P_REM_END, RA_AT_P1, WR_NONE, IX_AT,
                         EV_NONE};
      P_REM_SHIFT: w = '{NS_BRANCH, C_DN_MORE, P_REM_SHIFT, RA_IDX_P2, WR_SHIFT, IX_INC,
                         EV_NONE};
      P_REM_END:   w = '{NS_BRANCH, C_ALWAYS, P_EMIT, RA_ZERO, WR_NONE, IX_HOLD, EV_REMOVE};
      // search: walk from the front, one entry a step
      P_SRCH:      w = '{NS_NEXT, C_ALWAYS, P_IDLE, RA_ZERO, WR_NONE, IX_ZERO, EV_NONE};
      P_SRCH_SCAN: w = '{NS_BRANCH, C_SCAN_MORE, P_SRCH_SCAN, RA_IDX_P1, WR_NONE, IX_INC,
                         EV_SCAN};
      P_SRCH_TEST: w = '{NS_BRANCH, C_HIT, P_FOUND, RA_ZERO, WR_NONE, IX_HOLD, EV_NONE};
      P_MISS:      w = '{NS_BRANCH, C_ALWAYS, P_EMIT, RA_ZERO, WR_NONE, IX_HOLD, EV_MISS};
      P_FOUND:     w = '{NS_BRANCH, C_OP_REMOVE, P_REM, RA_ZERO, WR_NONE, IX_HOLD, EV_FOUND};
      P_FOUND_SEL: w = '{NS_BRANCH, C_OP_SEARCH, P_EMIT, RA_ZERO, WR_NONE, IX_HOLD, EV_NONE};
      P_SET:       w = '{NS_BRANCH, C_ALWAYS, P_EMIT, RA_ZERO, WR_STATUS, IX_HOLD, EV_NONE};
      // hand the result to the output register
      P_EMIT:      w = '{NS_WAIT, C_OUT_FREE, P_IDLE, RA_ZERO, WR_NONE, IX_HOLD, EV_EMIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### src/sequential_list_engine.sv
// Commands settled at decode go from decode straight to the result step; the others walk
// the entry memory, moving or scanning one entry per microcode step.
// Throughput: one command in work at a time; the next beat is taken the cycle after the
// result loads.
// The result register lets the next command enter while the last result waits.
// Reset empties the list and clears the id counter; entry memory is not cleared.
`default_nettype none

module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // operation[2:0], position[6:3], key_id[22:7], new_status[30:23], zero pad
  input  wire [S_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  // result_code[2:0], found_position[6:3], entry_count[11:7], assigned_id[27:12], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  ctrl_t  ctrl;
  flags_t flags;

  // Program sequencer
  sle_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // List datapath
  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .flags_o         (flags),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

### src/sle_sequencer.sv
// Microcode sequencer: step counter, program table lookup and branching.
`default_nettype none

module sle_sequencer
  import sle_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  pc_t   pc_q, pc_d;
  ctrl_t ctrl;
  logic  cond_true;

  // Fetch the control word of the current step
  assign ctrl   = ucode(pc_q);
  assign ctrl_o = ctrl;

  // Select the branch condition
  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:      cond_true = 1'b1;
      C_ACCEPT:      cond_true = flags_i.accept;
      C_OUT_FREE:    cond_true = flags_i.out_free;
      C_NO_SHIFT_UP: cond_true = flags_i.no_shift_up;
      C_UP_MORE:     cond_true = flags_i.up_more;
      C_NO_SHIFT_DN: cond_true = flags_i.no_shift_dn;
      C_DN_MORE:     cond_true = flags_i.dn_more;
      C_SCAN_MORE:   cond_true = flags_i.scan_more;
      C_HIT:         cond_true = flags_i.hit;
      C_OP_REMOVE:   cond_true = flags_i.op_remove;
      C_OP_SEARCH:   cond_true = flags_i.op_search;
      default:       cond_true = 1'b0;
    endcase
  end

  // Compute the next step
  always_comb begin
    unique case (ctrl.ns)
      NS_NEXT:     pc_d = pc_q + PC_W'(1);
      NS_BRANCH:   pc_d = cond_true ? ctrl.target : pc_q + PC_W'(1);
      NS_WAIT:     pc_d = cond_true ? ctrl.target : pc_q;
      NS_DISPATCH: pc_d = flags_i.dispatch;
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= P_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == P_IDLE && flags_i.accept) |=> pc_q == P_DECODE)
    else $error("accepted command did not enter decode");

  a_dispatch_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == P_DECODE) |-> (flags_i.dispatch == P_INS || flags_i.dispatch == P_REM ||
                            flags_i.dispatch == P_SRCH || flags_i.dispatch == P_EMIT))
    else $error("decode dispatched to a step that is no routine entry");

endmodule

`default_nettype wire

### src/sle_datapath.sv
// List datapath: command registers, entry memory, walk pointer and result register.
`default_nettype none

module sle_datapath
  import sle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ctrl_t                ctrl_i,
  output flags_t               flags_o,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // operation[2:0], position[6:3], key_id[22:7], new_status[30:23], zero pad
  input  wire [S_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  // result_code[2:0], found_position[6:3], entry_count[11:7], assigned_id[27:12], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW  = $clog2(CAPACITY + 1);
  localparam int OW1 = OW + 1;
  localparam int CW  = (OW > POS_W) ? OW : POS_W;

  // Command registers
  op_e                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [ID_BITS-1:0] key_q;
  logic [STAT_W-1:0]  st_q;

  // List state
  logic [OW-1:0]      occ_q;
  logic [ID_BITS-1:0] idc_q;
  logic [AW-1:0]      idx_q;
  logic [AW-1:0]      at_q;
  logic               hit_q;

  // Result registers
  rc_e                code_q;
  logic [FPOS_W-1:0]  fpos_q;
  logic [ID_BITS-1:0] newid_q;
  logic               m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  // Entry memory
  entry_t             mem [CAPACITY];
  entry_t             rd_q;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;

  // Decode signals
  logic [CW-1:0]      occ_w, pos_w, at_w;
  rc_e                dec_code;
  pc_t                dec_pc;
  logic               is_insert;
  logic               accept, out_free, emit_load, match;

  assign s_axis_tready_o = (ctrl_i.ev == EV_ACCEPT);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign emit_load       = (ctrl_i.ev == EV_EMIT) && out_free;
  assign match           = (rd_q.id == key_q);

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Check the command against occupancy and pick the routine
  always_comb begin
    occ_w     = CW'(occ_q);
    pos_w     = CW'(pos_q);
    is_insert = (op_q == OP_INS_FRONT) || (op_q == OP_INS_END) || (op_q == OP_INS_AT);
    unique case (op_q)
      OP_INS_FRONT: at_w = '0;
      OP_INS_END:   at_w = occ_w;
      default:      at_w = pos_w;
    endcase
    dec_code = RC_OK;
    dec_pc   = P_EMIT;
    priority if (is_insert) begin
      priority if (occ_w >= CW'(CAPACITY)) begin
        dec_code = RC_FULL;
      end else if (at_w > occ_w) begin
        dec_code = RC_RANGE;
      end else begin
        dec_pc = P_INS;
      end
    end else if (op_q == OP_NOP) begin
      dec_code = RC_OK;
    end else if (occ_q == '0) begin
      dec_code = RC_EMPTY;
    end else if (op_q == OP_REMOVE_AT) begin
      if (pos_w >= occ_w) begin
        dec_code = RC_RANGE;
      end else begin
        dec_pc = P_REM;
      end
    end else begin
      dec_pc = P_SRCH;
    end
  end

  // Report conditions to the sequencer
  always_comb begin
    flags_o.accept      = accept;
    flags_o.out_free    = out_free;
    flags_o.no_shift_up = (OW'(at_q) == occ_q);
    flags_o.up_more     = ((idx_q - AW'(1)) != at_q);
    flags_o.no_shift_dn = ((OW1'(at_q) + OW1'(1)) == OW1'(occ_q));
    flags_o.dn_more     = ((OW1'(idx_q) + OW1'(2)) != OW1'(occ_q));
    flags_o.scan_more   = !match && ((OW1'(idx_q) + OW1'(1)) != OW1'(occ_q));
    flags_o.hit         = hit_q;
    flags_o.op_remove   = (op_q == OP_REMOVE_ID);
    flags_o.op_search   = (op_q == OP_SEARCH);
    flags_o.dispatch    = dec_pc;
  end

  // Select the memory read address
  always_comb begin
    unique case (ctrl_i.ra)
      RA_ZERO:   rd_addr = '0;
      RA_OCC_M1: rd_addr = AW'(occ_q - OW'(1));
      RA_IDX_M2: rd_addr = idx_q - AW'(2);
      RA_AT_P1:  rd_addr = at_q + AW'(1);
      RA_IDX_P1: rd_addr = idx_q + AW'(1);
      RA_IDX_P2: rd_addr = idx_q + AW'(2);
      default:   rd_addr = '0;
    endcase
  end

  // Select the memory write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = at_q;
    wr_data = rd_q;
    unique case (ctrl_i.wr)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_q;
      end
      WR_NEW: begin
        wr_en          = 1'b1;
        wr_data.id     = idc_q + ID_BITS'(1);
        wr_data.status = '0;
      end
      WR_STATUS: begin
        wr_en          = 1'b1;
        wr_data.id     = key_q;
        wr_data.status = st_q;
      end
    endcase
  end

  // Write one entry and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Control state: occupancy, id counter, walk pointer, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      idc_q     <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      unique case (ctrl_i.ix)
        IX_OCC:  idx_q <= AW'(occ_q);
        IX_AT:   idx_q <= at_q;
        IX_ZERO: idx_q <= '0;
        IX_INC:  idx_q <= idx_q + AW'(1);
        IX_DEC:  idx_q <= idx_q - AW'(1);
        default: idx_q <= idx_q;
      endcase
      if (ctrl_i.ev == EV_INSERT) begin
        occ_q <= occ_q + OW'(1);
        idc_q <= idc_q + ID_BITS'(1);
      end else if (ctrl_i.ev == EV_REMOVE) begin
        occ_q <= occ_q - OW'(1);
      end
      if (emit_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload: command capture, walk results and the output beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(s_axis_tdata_i[OP_W-1:0]);
      pos_q <= s_axis_tdata_i[S_POS_LSB +: POS_W];
      key_q <= ID_BITS'(s_axis_tdata_i[S_KEY_LSB +: KEY_W]);
      st_q  <= s_axis_tdata_i[S_ST_LSB +: STAT_W];
    end
    unique case (ctrl_i.ev)
      EV_DECODE: begin
        code_q  <= dec_code;
        fpos_q  <= '0;
        newid_q <= '0;
        at_q    <= AW'(at_w);
      end
      EV_INSERT: begin
        fpos_q  <= FPOS_W'(at_q);
        newid_q <= idc_q + ID_BITS'(1);
      end
      EV_REMOVE, EV_FOUND: begin
        fpos_q <= FPOS_W'(at_q);
      end
      EV_SCAN: begin
        at_q  <= idx_q;
        hit_q <= match;
      end
      EV_MISS: begin
        code_q <= RC_NOTFOUND;
      end
      default: begin
      end
    endcase
    if (emit_load) begin
      m_data_q <= M_TDATA_W'({AID_W'(newid_q), CNT_W'(occ_q), fpos_q, code_q});
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OW1'(occ_q) <= OW1'(CAPACITY))
    else $error("occupancy above capacity");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == $past(occ_q) || occ_q == $past(occ_q) + OW'(1) ||
     occ_q == $past(occ_q) - OW'(1)))
    else $error("occupancy moved by more than one entry");

  a_id_with_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idc_q != $past(idc_q)) |-> (occ_q == $past(occ_q) + OW'(1)))
    else $error("id counter advanced without an insert");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[CODE_W-1:0] == RC_FULL) |->
      (m_data_q[CODE_W+FPOS_W +: CNT_W] == CNT_W'(CAPACITY)))
    else $error("full code reported with a list that is not full");

endmodule

`default_nettype wire
